// File: hdl/rbc_pkg.sv
// Shared types and codes for the reorder buffer commit core.
package rbc_pkg;

    localparam logic [2:0] CMD_ALLOC  = 3'd0;
    localparam logic [2:0] CMD_MARK   = 3'd1;
    localparam logic [2:0] CMD_FINISH = 3'd2;
    localparam logic [2:0] CMD_WRITE  = 3'd3;
    localparam logic [2:0] CMD_COMMIT = 3'd4;
    localparam logic [2:0] CMD_FLUSH  = 3'd5;

    localparam logic [1:0] ST_INVALID   = 2'd0;
    localparam logic [1:0] ST_ISSUED    = 2'd1;
    localparam logic [1:0] ST_EXECUTING = 2'd2;
    localparam logic [1:0] ST_FINISHED  = 2'd3;

    localparam logic [1:0] TY_REGWRITE = 2'd0;
    localparam logic [1:0] TY_JUMP     = 2'd1;
    localparam logic [1:0] TY_SYSCALL  = 2'd2;
    localparam logic [1:0] TY_OTHER    = 2'd3;

    localparam int META_W = 38;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  idx;
        logic [1:0]  etype;
        logic        pred;
        logic [31:0] target;
        logic [4:0]  dest;
        logic [31:0] result;
        logic        noop;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic        reg_write;
        logic [4:0]  wreg;
        logic [31:0] wval;
        logic        redirect;
        logic [31:0] pc;
        logic        halt;
        logic [31:0] retired;
    } t_rec;

    typedef struct packed {
        logic exec;
        logic eval;
        logic pop;
    } t_ctl;

    typedef struct packed {
        logic is_commit;
        logic stop;
        logic q_last;
    } t_stat;

endpackage

// File: hdl/reorder_buffer_commit_core.sv
// Top level of the reorder buffer commit core.
// One command is taken per input transfer and answered with one or more output
// transfers, the last one flagged by tlast. Allocate, mark, finish, write and
// flush are executed when taken and then their acknowledge is delivered; a
// commit takes the command and then, for each examined entry, does a
// registered read of the entry memories at the tail and then evaluates it, up
// to ISSUE_WIDTH entries; its records are queued and sent after the last one
// so that every record carries the final has_space and is_empty. A new command
// is taken once the last result of the previous one has been transferred. tuser
// carries kind (0 acknowledge, 1 commit record).
module reorder_buffer_commit_core import rbc_pkg::*; #(
    parameter int BUFFER_DEPTH  = 16,
    parameter int ISSUE_WIDTH   = 4,
    parameter int NUM_ARCH_REGS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // cmd, entry_index, entry_type, predicted_taken, target_address,
    // dest_register, result_value, is_noop
    input  logic [79:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // slot, has_space, is_empty, reg_write, write_register, write_value,
    // redirect, redirect_pc, halt, retired_total, 2 zero bits
    output logic [111:0] o_m_axis_tdata,
    // kind
    output logic         o_m_axis_tuser,
    output logic         o_m_axis_tlast
);
    t_item w_item;
    t_ctl  w_ctl;
    t_stat w_stat;
    t_rec  w_rec;
    logic  w_space, w_empty, w_flush;

    assign w_item.cmd    = i_s_axis_tdata[2:0];
    assign w_item.idx    = i_s_axis_tdata[6:3];
    assign w_item.etype  = i_s_axis_tdata[8:7];
    assign w_item.pred   = i_s_axis_tdata[9];
    assign w_item.target = i_s_axis_tdata[41:10];
    assign w_item.dest   = i_s_axis_tdata[46:42];
    assign w_item.result = i_s_axis_tdata[78:47];
    assign w_item.noop   = i_s_axis_tdata[79];

    rbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl)
    );

    rbc_datapath #(
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .ISSUE_WIDTH   (ISSUE_WIDTH),
        .NUM_ARCH_REGS (NUM_ARCH_REGS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_item  (w_item),
        .o_stat  (w_stat),
        .o_rec   (w_rec),
        .o_space (w_space),
        .o_empty (w_empty),
        .o_flush (w_flush)
    );

    assign o_m_axis_tdata = {2'b00, w_rec.retired, w_rec.halt, w_rec.pc,
                             (w_rec.kind ? w_rec.redirect : w_flush),
                             w_rec.wval, w_rec.wreg, w_rec.reg_write,
                             w_empty, w_space, w_rec.slot};
    assign o_m_axis_tuser = w_rec.kind;
    assign o_m_axis_tlast = w_stat.q_last;
endmodule

// File: hdl/rbc_ram.sv
// Generic simple dual-port RAM with registered read.
module rbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/rbc_ctrl.sv
// Sequencer for command execution, commit iterations and result delivery.
module rbc_ctrl import rbc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_ctl        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.exec = 1'b1;
                    n_state    = i_stat.is_commit ? S_READ : S_OUT;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_ctl.eval = 1'b1;
                n_state    = i_stat.stop ? S_OUT : S_READ;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_ctl.pop = 1'b1;
                    if (i_stat.q_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: hdl/rbc_datapath.sv
// Entry state, pointers, entry memories and result queue.
module rbc_datapath import rbc_pkg::*; #(
    parameter int BUFFER_DEPTH  = 16,
    parameter int ISSUE_WIDTH   = 4,
    parameter int NUM_ARCH_REGS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    input  t_item i_item,
    output t_stat o_stat,
    output t_rec  o_rec,
    output logic  o_space,
    output logic  o_empty,
    output logic  o_flush
);
    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int QW  = $clog2(ISSUE_WIDTH + 1);
    localparam int QIW = (ISSUE_WIDTH > 1) ? $clog2(ISSUE_WIDTH) : 1;

    logic [1:0]  r_status [BUFFER_DEPTH];
    logic [1:0]  r_type   [BUFFER_DEPTH];
    logic        r_noop   [BUFFER_DEPTH];
    logic [AW-1:0] r_head, r_tail;
    logic        r_flush;
    logic [31:0] r_retire;
    t_rec        r_q [ISSUE_WIDTH];
    logic [QW-1:0] r_qcnt;
    logic [QW-1:0] r_iter;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == AW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic          w_empty, w_space, w_alloc_ok, w_idx_ok;
    logic [AW-1:0] w_alloc_ptr, w_idx;
    logic          w_alloc, w_upd;
    logic [META_W-1:0] w_meta_rd;
    logic [31:0]   w_res_rd;
    logic          w_pred;
    logic [31:0]   w_target;
    logic [4:0]    w_dest;
    logic          w_fin, w_misp, w_stop;
    logic          w_res_we;
    logic [AW-1:0] w_res_wa;
    logic [31:0]   w_res_wd;
    logic          w_push;
    t_rec          w_new;
    logic [1:0]    w_ttype;

    assign w_empty     = (r_head == r_tail) && r_noop[r_head];
    assign w_space     = f_next(r_head) != r_tail;
    assign w_alloc_ok  = w_empty || w_space;
    assign w_alloc_ptr = w_empty ? r_head : f_next(r_head);
    assign w_idx       = AW'(i_item.idx);
    assign w_idx_ok    = 32'(i_item.idx) < BUFFER_DEPTH;
    assign w_alloc     = i_ctl.exec && (i_item.cmd == CMD_ALLOC) && w_alloc_ok;
    assign w_upd       = i_ctl.exec && w_idx_ok &&
                         ((i_item.cmd == CMD_FINISH) || (i_item.cmd == CMD_WRITE));

    assign w_res_we = w_alloc || w_upd;
    assign w_res_wa = w_alloc ? w_alloc_ptr : w_idx;
    assign w_res_wd = w_alloc ? 32'd0 : i_item.result;

    rbc_ram #(.WIDTH(META_W), .DEPTH(BUFFER_DEPTH)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_alloc),
        .i_waddr (w_alloc_ptr),
        .i_wdata ({i_item.pred, i_item.target, i_item.dest}),
        .i_raddr (r_tail),
        .o_rdata (w_meta_rd)
    );

    rbc_ram #(.WIDTH(32), .DEPTH(BUFFER_DEPTH)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (w_res_we),
        .i_waddr (w_res_wa),
        .i_wdata (w_res_wd),
        .i_raddr (r_tail),
        .o_rdata (w_res_rd)
    );

    assign {w_pred, w_target, w_dest} = w_meta_rd;
    assign w_ttype = r_type[r_tail];
    assign w_fin   = r_status[r_tail] == ST_FINISHED;
    assign w_misp  = (w_ttype == TY_JUMP) && (w_res_rd != {31'd0, w_pred});
    assign w_stop  = !w_fin || w_misp || (r_iter == QW'(ISSUE_WIDTH - 1));

    always_comb begin
        w_new  = '0;
        w_push = 1'b0;
        if (i_ctl.exec) begin
            w_push      = i_item.cmd != CMD_COMMIT;
            w_new.retired = r_retire;
            priority case (1'b1)
                i_item.cmd == CMD_ALLOC:
                    w_new.slot = 4'(w_alloc_ok ? w_alloc_ptr : r_head);
                (i_item.cmd == CMD_MARK) || (i_item.cmd == CMD_FINISH) ||
                (i_item.cmd == CMD_WRITE):
                    w_new.slot = i_item.idx;
                default: w_new.slot = 4'd0;
            endcase
        end else if (i_ctl.eval) begin
            if (w_fin) begin
                w_push        = 1'b1;
                w_new.kind    = 1'b1;
                w_new.slot    = 4'(r_tail);
                w_new.retired = r_retire + 32'd1;
                if (w_ttype == TY_REGWRITE) begin
                    if (32'(w_dest) < NUM_ARCH_REGS) begin
                        w_new.reg_write = 1'b1;
                        w_new.wreg      = w_dest;
                        w_new.wval      = w_res_rd;
                    end
                end else if (w_misp) begin
                    w_new.redirect = 1'b1;
                    w_new.pc       = w_target;
                end else if (w_ttype == TY_SYSCALL) begin
                    w_new.halt = 1'b1;
                end
            end else if (r_qcnt == '0) begin
                w_push        = 1'b1;
                w_new.slot    = 4'(r_tail);
                w_new.retired = r_retire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                r_status[i] <= ST_INVALID;
                r_type[i]   <= TY_OTHER;
                r_noop[i]   <= 1'b1;
            end
            r_head   <= '0;
            r_tail   <= '0;
            r_flush  <= 1'b0;
            r_retire <= '0;
            r_qcnt   <= '0;
            r_iter   <= '0;
        end else begin
            if (i_ctl.exec) begin
                r_iter <= '0;
                if (w_alloc) begin
                    r_head                <= w_alloc_ptr;
                    r_status[w_alloc_ptr] <= ST_ISSUED;
                    r_type[w_alloc_ptr]   <= i_item.etype;
                    r_noop[w_alloc_ptr]   <= i_item.noop;
                end
                if (w_idx_ok && (i_item.cmd == CMD_MARK)) begin
                    r_status[w_idx] <= ST_EXECUTING;
                end
                if (w_idx_ok && (i_item.cmd == CMD_FINISH)) begin
                    r_status[w_idx] <= ST_FINISHED;
                end
                if (i_item.cmd == CMD_FLUSH) begin
                    for (int i = 0; i < BUFFER_DEPTH; i++) begin
                        r_status[i] <= ST_INVALID;
                        r_type[i]   <= TY_OTHER;
                        r_noop[i]   <= 1'b1;
                    end
                    r_head  <= '0;
                    r_tail  <= '0;
                    r_flush <= 1'b0;
                end
            end
            if (i_ctl.eval) begin
                r_iter <= r_iter + 1'b1;
                if (w_fin) begin
                    r_retire <= r_retire + 32'd1;
                    if (w_misp) begin
                        r_flush <= 1'b1;
                    end else begin
                        r_status[r_tail] <= ST_INVALID;
                        r_type[r_tail]   <= TY_OTHER;
                        r_noop[r_tail]   <= 1'b1;
                        if (r_head != r_tail) begin
                            r_tail <= f_next(r_tail);
                        end
                    end
                end
            end
            if (w_push) begin
                r_qcnt <= r_qcnt + 1'b1;
            end else if (i_ctl.pop) begin
                r_qcnt <= r_qcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_qcnt[QIW-1:0]] <= w_new;
        end else if (i_ctl.pop) begin
            for (int i = 0; i < ISSUE_WIDTH - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
        end
    end

    assign o_stat.is_commit = i_item.cmd == CMD_COMMIT;
    assign o_stat.stop      = w_stop;
    assign o_stat.q_last    = r_qcnt == QW'(1);
    assign o_rec            = r_q[0];
    assign o_space          = w_space;
    assign o_empty          = w_empty;
    assign o_flush          = r_flush;

    a_qcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= QW'(ISSUE_WIDTH))
        else $error("result queue overflow");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.exec && (i_item.cmd == CMD_FLUSH)
        |=> (r_head == '0) && (r_tail == '0) && !r_flush)
        else $error("flush left pointers or redirect set");

    a_retire_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.eval && w_fin |=> r_retire == $past(r_retire) + 32'd1)
        else $error("retire count not advanced on commit");
endmodule
